/* hw/rtl/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// sfc_pkg: shared definitions for the clamped spring force unit
// Widths, register indexes, reset values and pipeline stage records.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  // Fixed-point format of coordinates and forces.
  localparam int CW    = 32;
  localparam int FRAC  = 16;
  localparam int REG_W = 31;

  // Derived widths.
  localparam int DW    = CW + 1;                       // coordinate difference
  localparam int MAGW  = CW + 1;                       // magnitude of a difference
  localparam int SQW   = 2 * MAGW;                     // one square
  localparam int SUMW  = SQW + 2;                      // sum of three squares
  localparam int RW    = CW + 1;                       // square root
  localparam int MW    = (RW > REG_W) ? RW : REG_W;    // stretch magnitude
  localparam int SW    = MW + 1;                       // signed stretch
  localparam int LPW   = MW + REG_W;                   // linear force product
  localparam int S2W   = 2 * MW;                       // stretch squared
  localparam int INW   = REG_W + 2 * FRAC;             // inverse-square numerator
  localparam int QW    = REG_W;                        // quotient bits
  localparam int CNW   = REG_W + MAGW;                 // component numerator
  localparam int IDW   = ((S2W > INW) ? S2W : INW) + QW + 1;
  localparam int CDW   = (((RW + QW) > CNW) ? (RW + QW) : CNW) + 1;
  localparam int SATW  = ((CW - 1) > QW) ? (CW - 1) : QW;

  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [DW-1:0]   diff_t;
  typedef logic        [MAGW-1:0] mag_t;
  typedef logic        [SQW-1:0]  sq_t;
  typedef logic        [SUMW-1:0] sum_t;
  typedef logic        [SUMW:0]   trial_t;
  typedef logic        [RW-1:0]   root_t;
  typedef logic signed [SW-1:0]   stretch_t;
  typedef logic        [MW-1:0]   smag_t;
  typedef logic        [LPW-1:0]  lp_t;
  typedef logic        [S2W-1:0]  s2_t;
  typedef logic        [INW-1:0]  inum_t;
  typedef logic        [QW-1:0]   quo_t;
  typedef logic        [REG_W-1:0] reg_t;
  typedef logic        [IDW-1:0]  idw_t;
  typedef logic        [CNW-1:0]  cnum_t;
  typedef logic        [CDW-1:0]  cdw_t;
  typedef logic        [SATW-1:0] sat_t;
  typedef logic        [DATA_W-1:0] data_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_MODE     = 2'd0,
    REG_STRENGTH = 2'd1,
    REG_REST     = 2'd2,
    REG_LIMIT    = 2'd3
  } reg_idx_t;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_INVSQ  = 1'b1;

  localparam reg_t STRENGTH_RST = reg_t'(655);
  localparam reg_t REST_RST     = reg_t'(0);
  localparam reg_t LIMIT_RST    = reg_t'(655360);

  // Largest component magnitude, symmetric for both signs.
  localparam sat_t CMAX = sat_t'((64'd1 << (CW - 1)) - 64'd1);

  // Square root stage record.
  typedef struct packed {
    sum_t           rem;
    root_t          root;
    logic [2:0]     dneg;
    mag_t [2:0]     dmag;
    logic           zero;
  } sqrt_st_t;

  // Force magnitude divider stage record.
  typedef struct packed {
    inum_t          rem;
    quo_t           q;
    s2_t            div;
    reg_t           lin;
    logic           isat;
    logic           fneg;
    logic           szero;
    root_t          len;
    logic [2:0]     dneg;
    mag_t [2:0]     dmag;
    logic           zero;
  } fdiv_st_t;

  // Component divider stage record, three lanes.
  typedef struct packed {
    cnum_t [2:0]    rem;
    quo_t  [2:0]    q;
    root_t          len;
    logic [2:0]     neg;
    logic           zero;
  } cdiv_st_t;

endpackage

`default_nettype wire

/* hw/rtl/sfc_ifs.sv */
// ----------------------------------------------------------------------------
// sfc_ifs: channel interfaces of the clamped spring force unit
// Anchor input channel, force result channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfc_in_if;
  logic            valid;
  logic            ready;
  sfc_pkg::coord_t first_x;
  sfc_pkg::coord_t first_y;
  sfc_pkg::coord_t first_z;
  sfc_pkg::coord_t second_x;
  sfc_pkg::coord_t second_y;
  sfc_pkg::coord_t second_z;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  output ready);
endinterface

interface sfc_out_if;
  logic            valid;
  logic            ready;
  sfc_pkg::coord_t force_x;
  sfc_pkg::coord_t force_y;
  sfc_pkg::coord_t force_z;
  logic            degenerate;
  modport source (output valid, force_x, force_y, force_z, degenerate, input ready);
  modport sink   (input valid, force_x, force_y, force_z, degenerate, output ready);
endinterface

interface sfc_cfg_if;
  logic              valid;
  logic              ready;
  sfc_pkg::reg_idx_t index;
  sfc_pkg::data_t    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/spring_force_clamped_unit.sv */
// ----------------------------------------------------------------------------
// spring_force_clamped_unit: clamped Hooke spring force between two anchors
// Forms the anchor difference, its length, the stretch against the rest
// length, a saturated scalar force and the force vector along the link.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   anchors   in         first_x/y/z, second_x/y/z (signed Q16.16)
//   result    out        force_x/y/z (signed Q16.16), degenerate
//   cfg       in         index (register number), data (write value)
//
// One beat enters per cycle while the result register is not blocked; the
// pipeline depth is set by the bit-per-stage square root (33
// stages) and the two bit-per-stage dividers (31 stages each).
// rst is synchronous: it empties the pipeline and loads the register defaults.
// While the result register holds a beat that is not taken, the whole
// pipeline holds; once it is taken everything moves one stage again.
// Register writes are taken in any cycle.
//
`default_nettype none

module spring_force_clamped_unit (
  input wire logic   clk,
  input wire logic   rst,
  sfc_in_if.sink     anchors,
  sfc_out_if.source  result,
  sfc_cfg_if.sink    cfg
);

  // Configuration registers.
  logic         mode;
  sfc_pkg::reg_t strength;
  sfc_pkg::reg_t rest;
  sfc_pkg::reg_t limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= sfc_pkg::MODE_LINEAR;
      strength <= sfc_pkg::STRENGTH_RST;
      rest     <= sfc_pkg::REST_RST;
      limit    <= sfc_pkg::LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        sfc_pkg::REG_MODE:     mode     <= cfg.data[0];
        sfc_pkg::REG_STRENGTH: strength <= cfg.data[sfc_pkg::REG_W-1:0];
        sfc_pkg::REG_REST:     rest     <= cfg.data[sfc_pkg::REG_W-1:0];
        sfc_pkg::REG_LIMIT:    limit    <= cfg.data[sfc_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole unless the result register is blocked.
  logic out_v;
  logic adv;
  assign adv = !out_v || result.ready;
  assign anchors.ready = adv;

  // Stage 1: coordinate differences, second minus first.
  logic            s1_v;
  sfc_pkg::diff_t  s1_d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= anchors.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d[0] <= sfc_pkg::diff_t'(anchors.second_x) - sfc_pkg::diff_t'(anchors.first_x);
      s1_d[1] <= sfc_pkg::diff_t'(anchors.second_y) - sfc_pkg::diff_t'(anchors.first_y);
      s1_d[2] <= sfc_pkg::diff_t'(anchors.second_z) - sfc_pkg::diff_t'(anchors.first_z);
    end
  end

  // Stage 2: magnitudes and their squares.
  logic                  s2_v;
  sfc_pkg::mag_t [2:0]   s2_mag;
  logic [2:0]            s2_neg;
  sfc_pkg::sq_t          s2_sq [3];
  sfc_pkg::mag_t [2:0]   mag_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = s1_d[i][sfc_pkg::DW-1] ? sfc_pkg::mag_t'(-s1_d[i])
                                         : sfc_pkg::mag_t'(s1_d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mag <= mag_c;
      for (int i = 0; i < 3; i++) begin
        s2_neg[i] <= s1_d[i][sfc_pkg::DW-1];
        s2_sq[i]  <= sfc_pkg::sq_t'(mag_c[i]) * sfc_pkg::sq_t'(mag_c[i]);
      end
    end
  end

  // Stage 3 and the square root: one result bit per stage, the remainder
  // carries the part of the sum not yet covered by the partial root.
  sfc_pkg::sqrt_st_t sq_p [0:sfc_pkg::RW];
  logic              sq_v [0:sfc_pkg::RW];
  sfc_pkg::sum_t     sum_c;

  assign sum_c = sfc_pkg::sum_t'(s2_sq[0]) + sfc_pkg::sum_t'(s2_sq[1])
               + sfc_pkg::sum_t'(s2_sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_p[0].rem  <= sum_c;
      sq_p[0].root <= '0;
      sq_p[0].dneg <= s2_neg;
      sq_p[0].dmag <= s2_mag;
      sq_p[0].zero <= (sum_c == '0);
    end
  end

  for (genvar k = 0; k < sfc_pkg::RW; k++) begin : g_sqrt
    localparam int B = sfc_pkg::RW - 1 - k;
    sfc_pkg::trial_t   trial;
    sfc_pkg::sqrt_st_t nxt;

    // Setting bit B raises the square by root*2^(B+1) + 2^(2B).
    always_comb begin
      trial = (sfc_pkg::trial_t'(sq_p[k].root) << (B + 1))
            | (sfc_pkg::trial_t'(1) << (2 * B));
      nxt = sq_p[k];
      if ({1'b0, sq_p[k].rem} >= trial) begin
        nxt.rem  = sq_p[k].rem - sfc_pkg::sum_t'(trial);
        nxt.root = sq_p[k].root | (sfc_pkg::root_t'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_p[k+1] <= nxt;
      end
    end
  end

  // Stage 4: stretch against the rest length.
  logic                s4_v;
  sfc_pkg::root_t      s4_len;
  sfc_pkg::smag_t      s4_smag;
  logic                s4_fneg;
  logic                s4_szero;
  logic [2:0]          s4_dneg;
  sfc_pkg::mag_t [2:0] s4_dmag;
  logic                s4_zero;
  sfc_pkg::stretch_t   stretch_c;

  assign stretch_c = sfc_pkg::stretch_t'(sq_p[sfc_pkg::RW].root)
                   - sfc_pkg::stretch_t'(rest);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= sq_v[sfc_pkg::RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_len   <= sq_p[sfc_pkg::RW].root;
      s4_smag  <= stretch_c[sfc_pkg::SW-1] ? sfc_pkg::smag_t'(-stretch_c)
                                           : sfc_pkg::smag_t'(stretch_c);
      s4_fneg  <= stretch_c[sfc_pkg::SW-1];
      s4_szero <= (stretch_c == '0);
      s4_dneg  <= sq_p[sfc_pkg::RW].dneg;
      s4_dmag  <= sq_p[sfc_pkg::RW].dmag;
      s4_zero  <= sq_p[sfc_pkg::RW].zero;
    end
  end

  // Stage 5: linear product and stretch squared.
  logic                s5_v;
  sfc_pkg::lp_t        s5_lp;
  sfc_pkg::s2_t        s5_s2;
  sfc_pkg::root_t      s5_len;
  logic                s5_fneg;
  logic                s5_szero;
  logic [2:0]          s5_dneg;
  sfc_pkg::mag_t [2:0] s5_dmag;
  logic                s5_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_lp    <= sfc_pkg::lp_t'(s4_smag) * sfc_pkg::lp_t'(strength);
      s5_s2    <= sfc_pkg::s2_t'(s4_smag) * sfc_pkg::s2_t'(s4_smag);
      s5_len   <= s4_len;
      s5_fneg  <= s4_fneg;
      s5_szero <= s4_szero;
      s5_dneg  <= s4_dneg;
      s5_dmag  <= s4_dmag;
      s5_zero  <= s4_zero;
    end
  end

  // Stage 6: saturated linear force, and the inverse-square division set up.
  // When the numerator reaches divisor*2^QW the quotient cannot fit under the
  // limit, so it is flagged as saturated and the divider only needs QW bits.
  sfc_pkg::fdiv_st_t fd_p [0:sfc_pkg::QW];
  logic              fd_v [0:sfc_pkg::QW];
  sfc_pkg::lp_t      lsh_c;
  sfc_pkg::inum_t    inum_c;

  assign lsh_c  = s5_lp >> sfc_pkg::FRAC;
  assign inum_c = sfc_pkg::inum_t'(strength) << (2 * sfc_pkg::FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      fd_v[0] <= 1'b0;
    end else if (adv) begin
      fd_v[0] <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fd_p[0].rem   <= inum_c;
      fd_p[0].q     <= '0;
      fd_p[0].div   <= s5_s2;
      fd_p[0].lin   <= (lsh_c > sfc_pkg::lp_t'(limit)) ? limit : sfc_pkg::reg_t'(lsh_c);
      fd_p[0].isat  <= sfc_pkg::idw_t'(inum_c) >= (sfc_pkg::idw_t'(s5_s2) << sfc_pkg::QW);
      fd_p[0].fneg  <= s5_fneg;
      fd_p[0].szero <= s5_szero;
      fd_p[0].len   <= s5_len;
      fd_p[0].dneg  <= s5_dneg;
      fd_p[0].dmag  <= s5_dmag;
      fd_p[0].zero  <= s5_zero;
    end
  end

  for (genvar k = 0; k < sfc_pkg::QW; k++) begin : g_fdiv
    localparam int I = sfc_pkg::QW - 1 - k;
    sfc_pkg::idw_t     shd;
    sfc_pkg::fdiv_st_t nxt;

    always_comb begin
      shd = sfc_pkg::idw_t'(fd_p[k].div) << I;
      nxt = fd_p[k];
      if (sfc_pkg::idw_t'(fd_p[k].rem) >= shd) begin
        nxt.rem  = fd_p[k].rem - sfc_pkg::inum_t'(shd);
        nxt.q[I] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        fd_v[k+1] <= 1'b0;
      end else if (adv) begin
        fd_v[k+1] <= fd_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fd_p[k+1] <= nxt;
      end
    end
  end

  // Stage 7: pick the force magnitude and scale each difference by it.
  sfc_pkg::fdiv_st_t fd_o;
  sfc_pkg::reg_t     fmag_c;
  logic              fneg_c;
  sfc_pkg::cdiv_st_t cd_p [0:sfc_pkg::QW];
  logic              cd_v [0:sfc_pkg::QW];

  assign fd_o = fd_p[sfc_pkg::QW];

  always_comb begin
    fmag_c = fd_o.lin;
    fneg_c = fd_o.fneg;
    if (mode == sfc_pkg::MODE_INVSQ) begin
      if (fd_o.szero) begin
        // Zero stretch pushes at the full limit.
        fmag_c = limit;
        fneg_c = 1'b0;
      end else if (fd_o.isat || (fd_o.q > limit)) begin
        fmag_c = limit;
      end else begin
        fmag_c = fd_o.q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_v[0] <= 1'b0;
    end else if (adv) begin
      cd_v[0] <= fd_v[sfc_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cd_p[0].rem[i] <= sfc_pkg::cnum_t'(fmag_c) * sfc_pkg::cnum_t'(fd_o.dmag[i]);
        cd_p[0].q[i]   <= '0;
        cd_p[0].neg[i] <= fneg_c ^ fd_o.dneg[i];
      end
      cd_p[0].len  <= fd_o.len;
      cd_p[0].zero <= fd_o.zero;
    end
  end

  // Component division by the length; each component is at most the force
  // magnitude, so QW quotient bits suffice.
  for (genvar k = 0; k < sfc_pkg::QW; k++) begin : g_cdiv
    localparam int I = sfc_pkg::QW - 1 - k;
    sfc_pkg::cdw_t     shd;
    sfc_pkg::cdiv_st_t nxt;

    always_comb begin
      shd = sfc_pkg::cdw_t'(cd_p[k].len) << I;
      nxt = cd_p[k];
      for (int i = 0; i < 3; i++) begin
        if (sfc_pkg::cdw_t'(cd_p[k].rem[i]) >= shd) begin
          nxt.rem[i]  = cd_p[k].rem[i] - sfc_pkg::cnum_t'(shd);
          nxt.q[i][I] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cd_v[k+1] <= 1'b0;
      end else if (adv) begin
        cd_v[k+1] <= cd_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cd_p[k+1] <= nxt;
      end
    end
  end

  // Output register: component saturation, sign and the degenerate case.
  sfc_pkg::cdiv_st_t cd_o;
  sfc_pkg::coord_t   comp_c [3];
  sfc_pkg::coord_t   out_f  [3];
  logic              out_deg;

  assign cd_o = cd_p[sfc_pkg::QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sfc_pkg::sat_t qz;
      sfc_pkg::coord_t mg;
      qz = sfc_pkg::sat_t'(cd_o.q[i]);
      mg = sfc_pkg::coord_t'((qz > sfc_pkg::CMAX) ? sfc_pkg::CMAX : qz);
      if (cd_o.zero) begin
        comp_c[i] = '0;
      end else begin
        comp_c[i] = cd_o.neg[i] ? -mg : mg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= cd_v[sfc_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_f   <= comp_c;
      out_deg <= cd_o.zero;
    end
  end

  assign result.valid      = out_v;
  assign result.force_x    = out_f[0];
  assign result.force_y    = out_f[1];
  assign result.force_z    = out_f[2];
  assign result.degenerate = out_deg;

endmodule

`default_nettype wire
